FILE: hdl/tlvp_pkg.sv
// Shared types, codes and header-layout tables for the TLV block parser.
// No dependencies; imported by tlvp_step and tlv_block_parser_top.
package tlvp_pkg;

  // Record kinds carried in record_kind
  localparam logic [1:0] KIND_HEADER    = 2'd0;
  localparam logic [1:0] KIND_VALUE     = 2'd1;
  localparam logic [1:0] KIND_BLOCK_END = 2'd2;

  // Header layouts selected by header_mode
  localparam logic [1:0] MODE_T1L1      = 2'd0;
  localparam logic [1:0] MODE_T1L2      = 2'd1;
  localparam logic [1:0] MODE_T1L2_INST = 2'd2;
  localparam logic [1:0] MODE_T2L2      = 2'd3;

  typedef enum logic [1:0] {
    ROLE_TYPE = 2'd0,
    ROLE_LEN  = 2'd1,
    ROLE_INST = 2'd2,
    ROLE_NONE = 2'd3
  } role_e;

  typedef struct packed {
    logic [2:0]  header_count;
    logic [15:0] type_acc;
    logic [15:0] length_acc;
    logic [7:0]  instance_acc;
    logic [15:0] value_remaining;
    logic        in_value;
  } parse_state_t;

  localparam parse_state_t PARSE_CLEAR = '0;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [15:0] element_type;
    logic [15:0] element_length;
    logic [7:0]  element_instance;
    logic [7:0]  value_byte;
    logic        value_last;
    logic        block_end;
    logic        block_error;
  } record_t;

  // Header size in bytes for each layout
  function automatic logic [2:0] hdr_size(input logic [1:0] mode);
    logic [2:0] size;
    case (mode)
      MODE_T1L1:      size = 3'd2;
      MODE_T1L2:      size = 3'd3;
      MODE_T1L2_INST: size = 3'd4;
      MODE_T2L2:      size = 3'd4;
      default:        size = 3'd4;
    endcase
    return size;
  endfunction

  // Role of a header byte position within each layout
  function automatic role_e hdr_role(input logic [1:0] mode, input logic [2:0] pos);
    role_e role;
    role = ROLE_NONE;
    case (mode)
      MODE_T1L1: begin
        case (pos)
          3'd0:    role = ROLE_TYPE;
          3'd1:    role = ROLE_LEN;
          default: role = ROLE_NONE;
        endcase
      end
      MODE_T1L2: begin
        case (pos)
          3'd0:    role = ROLE_TYPE;
          3'd1:    role = ROLE_LEN;
          3'd2:    role = ROLE_LEN;
          default: role = ROLE_NONE;
        endcase
      end
      MODE_T1L2_INST: begin
        case (pos)
          3'd0:    role = ROLE_TYPE;
          3'd1:    role = ROLE_LEN;
          3'd2:    role = ROLE_LEN;
          3'd3:    role = ROLE_INST;
          default: role = ROLE_NONE;
        endcase
      end
      MODE_T2L2: begin
        case (pos)
          3'd0:    role = ROLE_TYPE;
          3'd1:    role = ROLE_TYPE;
          3'd2:    role = ROLE_LEN;
          3'd3:    role = ROLE_LEN;
          default: role = ROLE_NONE;
        endcase
      end
      default: role = ROLE_NONE;
    endcase
    return role;
  endfunction

endpackage

FILE: hdl/tlvp_stream_if.sv
// Valid/ready stream interfaces for the TLV block parser: byte input and record output.
// Depends on nothing; used by tlv_block_parser_top.

interface tlvp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_last;

  modport source (output valid, output data_byte, output block_last, input ready);
  modport sink   (input valid, input data_byte, input block_last, output ready);
endinterface

interface tlvp_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [15:0] element_type;
  logic [15:0] element_length;
  logic [7:0]  element_instance;
  logic [7:0]  value_byte;
  logic        value_last;
  logic        block_end;
  logic        block_error;

  modport source (
    output valid, output record_kind, output element_type, output element_length,
    output element_instance, output value_byte, output value_last, output block_end,
    output block_error, input ready
  );
  modport sink (
    input valid, input record_kind, input element_type, input element_length,
    input element_instance, input value_byte, input value_last, input block_end,
    input block_error, output ready
  );
endinterface

FILE: hdl/tlv_block_parser_top.sv
// Top level of the TLV block parser: input register, parse step, result register.
// Depends on tlvp_pkg, tlvp_stream_if (tlvp_byte_if, tlvp_rec_if) and tlvp_step.

// The parser takes one byte of an encoded block per request on byte_i and splits the
// block into type-length-value elements whose header layout is chosen by header_mode
// (0: type 1 + length 1, 1: type 1 + length 2, 2: type 1 + length 2 + instance 1,
// 3: type 2 + length 2, all big-endian). A header record leaves on rec_o once the
// header completes; every value byte follows as its own record, the element's last
// one flagged. The block's final byte (block_last) always yields a record that carries
// block_end, and block_error when that byte does not close an element exactly; the
// parse state then returns to its start. Throughput is one byte per cycle while rec_o
// is not stalled: a byte is taken into the input register, parsed by a single
// combinational step, and its record is loaded into the result register, from which
// it is offered on rec_o. A stalled rec_o holds the input register and, through it,
// byte_i. Header bytes that do not complete a header produce no record.
// header_mode is written through cfg_we_i/cfg_data_i and should only change while
// the parser is idle.
module tlv_block_parser_top
  import tlvp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_data_i,
  tlvp_byte_if.sink  byte_i,
  tlvp_rec_if.source rec_o
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_last_q;
  logic [1:0]   header_mode_q;
  parse_state_t state_q;
  parse_state_t state_d;
  logic         out_valid_q;
  record_t      rec_q;
  record_t      rec_d;
  logic         step_valid;
  logic         out_free;
  logic         advance;
  logic         in_take;

  tlvp_step u_step (
    .state_i      (state_q),
    .mode_i       (header_mode_q),
    .data_byte_i  (in_byte_q),
    .block_last_i (in_last_q),
    .state_o      (state_d),
    .rec_valid_o  (step_valid),
    .rec_o        (rec_d)
  );

  // The result register frees up when empty or when its record is taken this cycle.
  // The input stage advances when its byte yields no record or the record has room.
  assign out_free     = ~out_valid_q | rec_o.ready;
  assign advance      = in_valid_q & (~step_valid | out_free);
  assign byte_i.ready = ~in_valid_q | advance;
  assign in_take      = byte_i.valid & byte_i.ready;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_mode_q <= MODE_T1L1;
    end else if (cfg_we_i) begin
      header_mode_q <= cfg_data_i;
    end
  end

  // Input register: hold the byte until the parse step consumes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= byte_i.data_byte;
      in_last_q <= byte_i.block_last;
    end
  end

  // Parse state: advance once per consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PARSE_CLEAR;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: load a new record, drop the old one once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && step_valid) begin
      out_valid_q <= 1'b1;
    end else if (rec_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step_valid) begin
      rec_q <= rec_d;
    end
  end

  assign rec_o.valid            = out_valid_q;
  assign rec_o.record_kind      = rec_q.record_kind;
  assign rec_o.element_type     = rec_q.element_type;
  assign rec_o.element_length   = rec_q.element_length;
  assign rec_o.element_instance = rec_q.element_instance;
  assign rec_o.value_byte       = rec_q.value_byte;
  assign rec_o.value_last       = rec_q.value_last;
  assign rec_o.block_end        = rec_q.block_end;
  assign rec_o.block_error      = rec_q.block_error;

endmodule

FILE: hdl/tlvp_step.sv
// Per-byte parse step: next parse state and the record one byte produces.
// Depends on tlvp_pkg.
module tlvp_step
  import tlvp_pkg::*;
(
  input  parse_state_t state_i,
  input  logic [1:0]   mode_i,
  input  logic [7:0]   data_byte_i,
  input  logic         block_last_i,
  output parse_state_t state_o,
  output logic         rec_valid_o,
  output record_t      rec_o
);

  role_e        role;
  logic [3:0]   count_inc;
  logic [15:0]  type_n;
  logic [15:0]  length_n;
  logic [7:0]   inst_n;
  logic         vlast;
  logic         zero_len;

  always_comb begin
    role      = hdr_role(mode_i, state_i.header_count);
    count_inc = {1'b0, state_i.header_count} + 4'd1;
    type_n    = state_i.type_acc;
    length_n  = state_i.length_acc;
    inst_n    = state_i.instance_acc;
    case (role)
      ROLE_TYPE: type_n   = {state_i.type_acc[7:0], data_byte_i};
      ROLE_LEN:  length_n = {state_i.length_acc[7:0], data_byte_i};
      ROLE_INST: inst_n   = data_byte_i;
      default:   ;
    endcase
    vlast    = (state_i.value_remaining == 16'd1);
    zero_len = (length_n == 16'd0);

    state_o     = state_i;
    rec_valid_o = 1'b0;
    rec_o       = '0;

    if (state_i.in_value) begin
      rec_valid_o       = 1'b1;
      rec_o.record_kind = KIND_VALUE;
      rec_o.value_byte  = data_byte_i;
      rec_o.value_last  = vlast;
      rec_o.block_end   = block_last_i;
      rec_o.block_error = block_last_i & ~vlast;
      state_o.value_remaining = state_i.value_remaining - 16'd1;
      if (vlast) begin
        state_o.in_value = 1'b0;
      end
      if (block_last_i) begin
        state_o = PARSE_CLEAR;
      end
    end else if (count_inc >= {1'b0, hdr_size(mode_i)}) begin
      // Header complete: report it and open the value, if any
      rec_valid_o            = 1'b1;
      rec_o.record_kind      = KIND_HEADER;
      rec_o.element_type     = type_n;
      rec_o.element_length   = length_n;
      rec_o.element_instance = (mode_i == MODE_T1L2_INST) ? inst_n : 8'd0;
      rec_o.value_last       = zero_len;
      rec_o.block_end        = block_last_i;
      rec_o.block_error      = block_last_i & ~zero_len;
      state_o                 = PARSE_CLEAR;
      state_o.value_remaining = length_n;
      state_o.in_value        = ~zero_len;
      if (block_last_i) begin
        state_o = PARSE_CLEAR;
      end
    end else if (block_last_i) begin
      // Block ends part-way through a header
      rec_valid_o       = 1'b1;
      rec_o.record_kind = KIND_BLOCK_END;
      rec_o.block_end   = 1'b1;
      rec_o.block_error = 1'b1;
      state_o           = PARSE_CLEAR;
    end else begin
      state_o.header_count = count_inc[2:0];
      state_o.type_acc     = type_n;
      state_o.length_acc   = length_n;
      state_o.instance_acc = inst_n;
    end
  end

endmodule
